// ===== design/rc4_pkg.sv =====
// rc4_pkg: shared widths, item classification codes, queue entry and
// sequencer state types for the rc4 stream cipher
// no dependencies
`default_nettype none

package rc4_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PERM_DEPTH  = 256;
  localparam int unsigned KEY_MAX_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 2;

  // class of a queued item
  typedef enum logic [1:0] {
    OP_KEY,
    OP_KEY_LAST,
    OP_DATA
  } op_t;

  // one queue entry between front and back
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSA_INIT,
    ST_KSA_RD,
    ST_KSA_J,
    ST_KSA_W0,
    ST_KSA_W1,
    ST_PRGA_J,
    ST_PRGA_W0,
    ST_PRGA_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/rc4_ram.sv =====
// rc4_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read of the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/rc4_front.sv =====
// rc4_front: accepts input beats, classifies them and queues them for the back end
// depends on rc4_pkg
`default_nettype none

module rc4_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           action,
  input  wire logic [rc4_pkg::BYTE_W-1:0]     byte_in,
  input  wire logic                           last,
  output logic                                q_valid,
  output rc4_pkg::item_t                      q_item,
  input  wire logic                           q_pop
);

  import rc4_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  item_t            new_item;

  // classify the incoming beat
  always_comb begin
    new_item.data = byte_in;
    new_item.last = last;
    if (action) begin
      new_item.op = OP_DATA;
    end else if (last) begin
      new_item.op = OP_KEY_LAST;
    end else begin
      new_item.op = OP_KEY;
    end
  end

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rc4_back.sv =====
// rc4_back: key store, key scheduling and keystream sequencer with output register
// depends on rc4_pkg and rc4_ram
`default_nettype none

module rc4_back #(
  parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire rc4_pkg::item_t             q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]      byte_out,
  output logic                            last_out
);

  import rc4_pkg::*;

  localparam int unsigned KA_W  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(KEY_MAX + 1);
  localparam int unsigned PA_W  = $clog2(PERM_DEPTH);

  state_t state;
  state_t state_next;

  logic [PA_W-1:0]   index_i;
  logic [PA_W-1:0]   index_j;
  logic [CNT_W-1:0]  key_count;
  logic [KA_W-1:0]   kidx;
  logic [PA_W-1:0]   ksa_n;
  logic [BYTE_W-1:0] sa;
  logic [BYTE_W-1:0] sb;
  logic [PA_W-1:0]   t_q;
  logic              hit_i;
  logic              hit_j;
  logic [BYTE_W-1:0] data_q;
  logic              last_q;

  logic [PERM_DEPTH-1:0] perm_vld;
  logic                  p_vld_q;
  logic [PA_W-1:0]       p_addr_q;

  logic              p_we;
  logic [PA_W-1:0]   p_waddr;
  logic [BYTE_W-1:0] p_wdata;
  logic [PA_W-1:0]   p_raddr;
  logic [BYTE_W-1:0] p_rdata;
  logic [BYTE_W-1:0] pval;

  logic              k_we;
  logic [BYTE_W-1:0] k_rdata;

  logic [PA_W-1:0]   i_inc;
  logic [PA_W-1:0]   j_prga;
  logic [PA_W-1:0]   j_ksa;
  logic [PA_W-1:0]   t_sum;
  logic              key_room;
  logic              kidx_wrap;
  logic              out_load;
  logic [BYTE_W-1:0] ks;

  // permutation entry not yet written since scheduling reads as its index
  assign pval = p_vld_q ? p_rdata : p_addr_q;

  assign i_inc     = index_i + 1'b1;
  assign j_prga    = index_j + pval;
  assign j_ksa     = index_j + pval + k_rdata;
  assign t_sum     = sa + pval;
  assign key_room  = (key_count < CNT_W'(KEY_MAX));
  assign kidx_wrap = ((CNT_W'(kidx) + 1'b1) == key_count);
  assign out_load  = (state == ST_PRGA_OUT) && (!out_valid || out_ready);
  assign ks        = hit_j ? sa : (hit_i ? sb : pval);

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX)
  ) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_count[KA_W-1:0]),
    .wdata (q_item.data),
    .raddr (kidx),
    .rdata (k_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_DATA:     state_next = ST_PRGA_J;
            OP_KEY_LAST: state_next = ST_KSA_INIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_KSA_INIT: state_next = ST_KSA_RD;
      ST_KSA_RD:   state_next = ST_KSA_J;
      ST_KSA_J:    state_next = ST_KSA_W0;
      ST_KSA_W0:   state_next = ST_KSA_W1;
      ST_KSA_W1:   state_next = (ksa_n == '1) ? ST_IDLE : ST_KSA_RD;
      ST_PRGA_J:   state_next = ST_PRGA_W0;
      ST_PRGA_W0:  state_next = ST_PRGA_OUT;
      ST_PRGA_OUT: state_next = out_load ? ST_IDLE : ST_PRGA_OUT;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory and queue controls
  always_comb begin
    q_pop   = 1'b0;
    k_we    = 1'b0;
    p_we    = 1'b0;
    p_waddr = index_j;
    p_wdata = sa;
    p_raddr = t_q;
    unique case (state)
      ST_IDLE: begin
        q_pop   = q_valid;
        k_we    = q_valid && (q_item.op != OP_DATA) && key_room;
        p_raddr = i_inc;
      end
      ST_KSA_RD: begin
        p_raddr = ksa_n;
      end
      ST_KSA_J: begin
        p_raddr = j_ksa;
      end
      ST_KSA_W0: begin
        p_we    = 1'b1;
        p_waddr = ksa_n;
        p_wdata = pval;
      end
      ST_KSA_W1: begin
        p_we    = 1'b1;
        p_waddr = index_j;
        p_wdata = sa;
      end
      ST_PRGA_J: begin
        p_raddr = j_prga;
      end
      ST_PRGA_W0: begin
        p_we    = 1'b1;
        p_waddr = index_i;
        p_wdata = pval;
        p_raddr = t_sum;
      end
      ST_PRGA_OUT: begin
        p_we    = 1'b1;
        p_waddr = index_j;
        p_wdata = sa;
        p_raddr = t_q;
      end
      default: begin
        p_raddr = t_q;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      index_i   <= '0;
      index_j   <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid && (q_item.op == OP_DATA)) begin
            index_i <= i_inc;
          end else if (k_we) begin
            key_count <= key_count + 1'b1;
          end
        end
        ST_KSA_INIT: begin
          index_i <= '0;
          index_j <= '0;
        end
        ST_KSA_J: begin
          index_j <= j_ksa;
        end
        ST_KSA_W1: begin
          if (ksa_n == '1) begin
            index_j   <= '0;
            key_count <= '0;
          end
        end
        ST_PRGA_J: begin
          index_j <= j_prga;
        end
        default: begin
          index_i <= index_i;
        end
      endcase
    end
  end

  // written-since-scheduling marks of the permutation
  always_ff @(posedge clk) begin
    if (rst || (state == ST_KSA_INIT)) begin
      perm_vld <= '0;
    end else if (p_we) begin
      perm_vld[p_waddr] <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_vld_q  <= perm_vld[p_raddr];
    p_addr_q <= p_raddr;
    unique case (state)
      ST_IDLE: begin
        data_q <= q_item.data;
        last_q <= q_item.last;
      end
      ST_KSA_INIT: begin
        ksa_n <= '0;
        kidx  <= '0;
      end
      ST_KSA_J: begin
        sa <= pval;
      end
      ST_KSA_W1: begin
        ksa_n <= ksa_n + 1'b1;
        kidx  <= kidx_wrap ? '0 : kidx + 1'b1;
      end
      ST_PRGA_J: begin
        sa <= pval;
      end
      ST_PRGA_W0: begin
        sb    <= pval;
        t_q   <= t_sum;
        hit_i <= (t_sum == index_i);
        hit_j <= (t_sum == index_j);
      end
      default: begin
        sa <= sa;
      end
    endcase
    if (out_load) begin
      byte_out <= data_q ^ ks;
      last_out <= last_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/rc4_stream_cipher.sv =====
// rc4_stream_cipher: top level of the rc4 engine
// depends on rc4_pkg, rc4_front, rc4_back (and rc4_ram through rc4_back)
//
// Usage: one input channel (in_valid/in_ready; action, byte_in, last) and one
// output channel (out_valid/out_ready; byte_out, last_out). A beat with action
// 0 is a key byte and is stored; beats past KEY_MAX stored bytes are dropped.
// A key beat with last set runs key scheduling over the stored key, after
// which a new key starts. A beat with action 1 is a data byte and gives one
// output beat, the byte XORed with the next keystream byte, last copied.
// Input beats enter a two-entry queue. The back end stores a key byte as it
// pops it. For a data byte it reads S[i], S[j], then S[t] while writing S[i],
// and writes S[j] last, on the separate read and write ports of the permutation
// ram; scheduling runs 256 steps of read, j update and two writes on the same
// ram. A data byte goes on through ST_PRGA_J and ST_PRGA_W0 to ST_PRGA_OUT,
// which loads the output register. Reset clears indices, key count and the
// permutation to identity at once through per-entry marks; no sweep is
// needed. On a receiver stall the result waits in the output register, key
// bytes go on until a later data byte waits; the queue takes beats until full.
`default_nettype none

module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       action,
  input  wire logic [rc4_pkg::BYTE_W-1:0] byte_in,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]      byte_out,
  output logic                            last_out
);

  import rc4_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // intake and queue
  rc4_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .byte_in  (byte_in),
    .last     (last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // key store, scheduling and keystream
  rc4_back #(
    .KEY_MAX (KEY_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .byte_out  (byte_out),
    .last_out  (last_out)
  );

endmodule

`default_nettype wire
